FILE: hw/rtl/lpi_pkg.sv
// Shared types, constants and register codes for the LED position indicator.
package lpi_pkg;

	localparam int NUM_LEDS_DEF = 59;
	localparam int LED_IDX_W    = 6;
	localparam int HEIGHT_W     = 12;
	localparam int GAIN_W       = 16;
	localparam int OFFSET_W     = 20;
	localparam int BRIGHT_W     = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 20;
	localparam int PROD_W       = GAIN_W + HEIGHT_W;
	localparam int RAW_IDX_W    = PROD_W - 16;

	localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd4463;
	localparam logic [OFFSET_W-1:0] OFFSET_RST = 20'd359641;
	localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 5'd5;

	localparam logic [2:0] LED_HDR    = 3'b111;
	localparam logic [7:0] GRAY_LEVEL = 8'h44;
	localparam logic [7:0] FULL_LEVEL = 8'hFF;
	localparam logic [7:0] OFF_LEVEL  = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INDEX_GAIN   = 2'd0,
		REG_INDEX_OFFSET = 2'd1,
		REG_BRIGHTNESS   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] sensor_height;
		logic [HEIGHT_W-1:0] setpoint_height;
	} in_t;

	typedef struct packed {
		logic [31:0] frame_word;
		logic        last_word;
	} out_t;

	// One classified refresh handed from the front to the back.
	typedef struct packed {
		logic [LED_IDX_W-1:0] pos;
		logic [RAW_IDX_W-1:0] tgt;
		logic                 on_target;
	} cmd_t;

	// Queue handshake between front, queue and back.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: hw/rtl/led_position_indicator_frame_generator.sv
// Top level of the LED position indicator frame generator for an APA102 strip.
//
// Each input beat carries a measured and a setpoint height; the block maps
// both to LED indices as (gain*h - offset) >> 16 in Q16, clamping negative
// results to zero and capping the position at NUM_LEDS, updates a sticky
// on-target flag, and then emits one full strip refresh: a zero start frame,
// NUM_LEDS LED words and an all-ones end frame marked by last_word. A refresh
// occupies the output for its NUM_LEDS + 2 words plus a gap in which the back
// end picks up the next command, so the word walker in the back end sets the
// rate at which height beats are taken. The front end takes a beat every cycle
// unless its stage register and the command queue are both full, registers the
// products before pushing the command and, thanks to a two-entry command
// queue, can take up to three beats ahead of the refresh currently being
// sent. Configuration registers (gain, offset, brightness) should only be
// written while the block is idle; brightness is applied as the words are
// emitted.
module led_position_indicator_frame_generator #(
	parameter int NUM_LEDS = lpi_pkg::NUM_LEDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  lpi_pkg::in_t                     in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output lpi_pkg::out_t                    out_data,
	input  logic                             cfg_we,
	input  logic [lpi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpi_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lpi_pkg::*;

	logic [GAIN_W-1:0]   index_gain_q;
	logic [OFFSET_W-1:0] index_offset_q;
	logic [BRIGHT_W-1:0] brightness_q;

	q_status_t q_status;
	cmd_t      push_cmd;
	cmd_t      pop_cmd;
	logic      push;
	logic      pop;

	// Configuration registers; writes to unused indices are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_gain_q   <= GAIN_RST;
			index_offset_q <= OFFSET_RST;
			brightness_q   <= BRIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INDEX_GAIN:   index_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_INDEX_OFFSET: index_offset_q <= cfg_data[OFFSET_W-1:0];
				REG_BRIGHTNESS:   brightness_q   <= cfg_data[BRIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end classifies each height beat into a refresh command.
	lpi_front #(
		.NUM_LEDS(NUM_LEDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.index_gain   (index_gain_q),
		.index_offset (index_offset_q),
		.q_status     (q_status),
		.push         (push),
		.cmd          (push_cmd)
	);

	// Commands wait here while the back end is busy with a refresh.
	lpi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_status (q_status)
	);

	// The back end turns commands into strip words, one per cycle unless stalled.
	lpi_back #(
		.NUM_LEDS(NUM_LEDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.pop_cmd    (pop_cmd),
		.pop        (pop),
		.brightness (brightness_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

FILE: hw/rtl/lpi_front.sv
// Front part: accepts height beats, maps them to LED indices and updates the flag.
module lpi_front #(
	parameter int NUM_LEDS = lpi_pkg::NUM_LEDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  lpi_pkg::in_t                   in_data,
	input  logic [lpi_pkg::GAIN_W-1:0]     index_gain,
	input  logic [lpi_pkg::OFFSET_W-1:0]   index_offset,
	input  lpi_pkg::q_status_t             q_status,
	output logic                           push,
	output lpi_pkg::cmd_t                  cmd
);
	import lpi_pkg::*;

	logic              valid_s1;
	logic [PROD_W-1:0] pos_prod_s1;
	logic [PROD_W-1:0] tgt_prod_s1;
	logic              on_target_q;
	logic              accept;
	logic              advance;
	logic [PROD_W:0]   pos_diff;
	logic [PROD_W:0]   tgt_diff;
	logic [RAW_IDX_W-1:0] pos_raw;
	logic [RAW_IDX_W-1:0] tgt_raw;
	logic [LED_IDX_W-1:0] pos_idx;
	logic [RAW_IDX_W:0]   pos_w;
	logic [RAW_IDX_W:0]   tgt_w;
	logic                 equal;
	logic                 near;
	logic                 flag_next;

	assign advance  = !valid_s1 || !q_status.full;
	assign in_stall = !advance;
	assign accept   = in_valid && advance;
	assign push     = valid_s1 && !q_status.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_prod_s1 <= index_gain * in_data.sensor_height;
			tgt_prod_s1 <= index_gain * in_data.setpoint_height;
		end
	end

	// A negative difference clamps to index zero; otherwise the Q16 fraction is dropped.
	always_comb begin
		pos_diff = {1'b0, pos_prod_s1} - (PROD_W+1)'(index_offset);
		tgt_diff = {1'b0, tgt_prod_s1} - (PROD_W+1)'(index_offset);
		pos_raw  = pos_diff[PROD_W] ? '0 : pos_diff[PROD_W-1:16];
		tgt_raw  = tgt_diff[PROD_W] ? '0 : tgt_diff[PROD_W-1:16];
		if (pos_raw > RAW_IDX_W'(NUM_LEDS)) begin
			pos_idx = LED_IDX_W'(NUM_LEDS);
		end else begin
			pos_idx = pos_raw[LED_IDX_W-1:0];
		end
		pos_w     = (RAW_IDX_W+1)'(pos_idx);
		tgt_w     = {1'b0, tgt_raw};
		equal     = (pos_w == tgt_w);
		near      = equal || (pos_w + 1'b1 == tgt_w) || (tgt_w + 1'b1 == pos_w);
		flag_next = equal || (on_target_q && near);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_target_q <= 1'b0;
		end else if (push) begin
			on_target_q <= flag_next;
		end
	end

	assign cmd.pos       = pos_idx;
	assign cmd.tgt       = tgt_raw;
	assign cmd.on_target = flag_next;

endmodule

FILE: hw/rtl/lpi_queue.sv
// Two-entry queue of classified refresh commands between front and back.
module lpi_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lpi_pkg::cmd_t       push_cmd,
	input  logic                pop,
	output lpi_pkg::cmd_t       pop_cmd,
	output lpi_pkg::q_status_t  q_status
);
	import lpi_pkg::*;

	localparam int DEPTH = 2;

	cmd_t       entry_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign pop_cmd        = entry_q[rd_ptr_q];
	assign q_status.full  = (count_q == 2'(DEPTH));
	assign q_status.empty = (count_q == 2'd0);

endmodule

FILE: hw/rtl/lpi_back.sv
// Back part: walks one refresh and emits its strip words through an output register.
module lpi_back #(
	parameter int NUM_LEDS = lpi_pkg::NUM_LEDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lpi_pkg::q_status_t             q_status,
	input  lpi_pkg::cmd_t                  pop_cmd,
	output logic                           pop,
	input  logic [lpi_pkg::BRIGHT_W-1:0]   brightness,
	output logic                           out_valid,
	input  logic                           out_stall,
	output lpi_pkg::out_t                  out_data
);
	import lpi_pkg::*;

	localparam logic [LED_IDX_W-1:0] LAST_CNT = LED_IDX_W'(NUM_LEDS + 1);

	logic                 active_q;
	logic [LED_IDX_W-1:0] cnt_q;
	cmd_t                 cmd_q;
	logic                 out_valid_q;
	out_t                 out_q;
	logic                 room;
	logic [LED_IDX_W-1:0] led;
	logic [7:0]           hdr;
	out_t                 word;

	assign room = !out_valid_q || !out_stall;
	assign pop  = room && !active_q && !q_status.empty;

	always_comb begin
		led = cnt_q - 1'b1;
		hdr = {LED_HDR, brightness};
		word.last_word = 1'b0;
		if (cnt_q == '0) begin
			word.frame_word = '0;
		end else if (cnt_q == LAST_CNT) begin
			word.frame_word = '1;
			word.last_word  = 1'b1;
		end else if (cmd_q.on_target) begin
			word.frame_word = {hdr, OFF_LEVEL, FULL_LEVEL, OFF_LEVEL};
		end else if (led == cmd_q.pos) begin
			word.frame_word = {hdr, GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL};
		end else if (RAW_IDX_W'(led) == cmd_q.tgt) begin
			word.frame_word = {hdr, OFF_LEVEL, OFF_LEVEL, FULL_LEVEL};
		end else begin
			word.frame_word = {hdr, OFF_LEVEL, OFF_LEVEL, OFF_LEVEL};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (room) begin
			out_valid_q <= active_q;
			if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					active_q <= 1'b0;
				end
			end else if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_cmd;
		end
		if (room && active_q) begin
			out_q <= word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
